// ===== sv/crc16_packet_framer_core_defines.svh =====
// assertion helpers used by the framer controller
`ifndef CRC16_PACKET_FRAMER_CORE_DEFINES_SVH
`define CRC16_PACKET_FRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// property holds at every clock edge outside reset
`define CRCPF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// expression never true outside reset
`define CRCPF_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CRCPF_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRCPF_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== sv/crcpf_pkg.sv =====
package crcpf_pkg;

    localparam int unsigned PayloadBytesDef = 6;
    localparam logic [15:0] CrcPoly         = 16'hA001;
    localparam logic [15:0] CrcInit         = 16'hFFFF;
    localparam logic [7:0]  HeaderReset     = 8'hAA;

    // source of the next output word
    typedef enum logic [1:0] {
        SEL_HDR  = 2'd0,
        SEL_PAY  = 2'd1,
        SEL_CRCL = 2'd2,
        SEL_CRCH = 2'd3
    } t_out_sel;

    typedef struct packed {
        logic     wr_en;   // store input word and fold it into the crc
        logic     rd_en;   // read payload store into read register
        logic     load;    // load output register
        t_out_sel sel;
        logic     crc_clr; // restart crc for the next frame
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;   // output register free or being drained
    } t_dp_stat;

    // crc-16/modbus over one byte, lsb first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CrcPoly;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/crcpf_ctrl.sv =====
`include "crc16_packet_framer_core_defines.svh"

module crcpf_ctrl #(
    parameter int unsigned PAYLOAD_BYTES = crcpf_pkg::PayloadBytesDef,
    localparam int unsigned CntW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  crcpf_pkg::t_dp_stat i_stat,
    output crcpf_pkg::t_dp_cmd  o_cmd,
    output logic [CntW-1:0]    o_addr
);

    typedef enum logic [5:0] {
        ST_COLLECT = 6'b000001,
        ST_HDR     = 6'b000010,
        ST_FETCH   = 6'b000100,
        ST_PAY     = 6'b001000,
        ST_CRCL    = 6'b010000,
        ST_CRCH    = 6'b100000
    } t_state;

    localparam logic [CntW-1:0] CntLast = CntW'(PAYLOAD_BYTES - 1);

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_in_ready = (r_state == ST_COLLECT);
    assign o_addr     = r_cnt;

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        o_cmd         = '0;
        o_cmd.sel     = crcpf_pkg::SEL_HDR;
        case (r_state)
            ST_COLLECT: begin
                if (i_in_valid) begin
                    o_cmd.wr_en = 1'b1;
                    if (r_cnt == CntLast) begin
                        n_cnt   = '0;
                        n_state = ST_HDR;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            ST_HDR: begin
                if (i_stat.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = crcpf_pkg::SEL_HDR;
                    n_state    = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_PAY;
            end
            ST_PAY: begin
                if (i_stat.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = crcpf_pkg::SEL_PAY;
                    if (r_cnt == CntLast) begin
                        n_cnt   = '0;
                        n_state = ST_CRCL;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_CRCL: begin
                if (i_stat.slot_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.sel  = crcpf_pkg::SEL_CRCL;
                    n_state    = ST_CRCH;
                end
            end
            ST_CRCH: begin
                if (i_stat.slot_free) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.sel     = crcpf_pkg::SEL_CRCH;
                    o_cmd.crc_clr = 1'b1;
                    n_state       = ST_COLLECT;
                end
            end
            default: begin
                n_state = ST_COLLECT;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `CRCPF_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CntLast, "byte counter out of range")
    `CRCPF_ASSERT(a_last_in_starts_frame, i_clk, i_rst_n, (r_state == ST_COLLECT && i_in_valid && r_cnt == CntLast) |=> (r_state == ST_HDR && r_cnt == '0), "frame did not start after last payload word")
    `CRCPF_ASSERT(a_crch_ends_frame, i_clk, i_rst_n, (r_state == ST_CRCH && i_stat.slot_free) |=> (r_state == ST_COLLECT && r_cnt == '0), "frame did not close after crc high word")

endmodule

// ===== sv/crcpf_dp.sv =====
module crcpf_dp #(
    parameter int unsigned PAYLOAD_BYTES = crcpf_pkg::PayloadBytesDef,
    localparam int unsigned CntW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  crcpf_pkg::t_dp_cmd  i_cmd,
    input  logic [CntW-1:0]     i_addr,
    input  logic [7:0]          i_data,
    input  logic [7:0]          i_header,
    output crcpf_pkg::t_dp_stat o_stat,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_out_byte,
    output logic                o_out_last
);

    logic [7:0]  r_mem [PAYLOAD_BYTES];
    logic [7:0]  r_rd_data;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    assign o_stat.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_out_last       = r_out_last;

    // payload store, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_addr] <= i_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc <= crcpf_pkg::CrcInit;
        end else if (i_cmd.crc_clr) begin
            r_crc <= crcpf_pkg::CrcInit;
        end else if (i_cmd.wr_en) begin
            r_crc <= crcpf_pkg::crc_fold(r_crc, i_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_last <= (i_cmd.sel == crcpf_pkg::SEL_CRCH);
            case (i_cmd.sel)
                crcpf_pkg::SEL_HDR:  r_out_byte <= i_header;
                crcpf_pkg::SEL_PAY:  r_out_byte <= r_rd_data;
                crcpf_pkg::SEL_CRCL: r_out_byte <= r_crc[7:0];
                crcpf_pkg::SEL_CRCH: r_out_byte <= r_crc[15:8];
                default:             r_out_byte <= i_header;
            endcase
        end
    end

endmodule

// ===== sv/crc16_packet_framer_core.sv =====
// throughput: one input word per cycle while collecting; a frame of PAYLOAD_BYTES+3
// words (header, payload words, crc low, crc high) is sent once the last payload
// word is accepted, each payload word read through the registered read port of
// the payload store; no input is taken while the frame is sent
// reset: synchronous active low; clears controller, byte count, crc to 0xffff,
// header register to 0xaa and output valid; payload store is not cleared
module crc16_packet_framer_core #(
    parameter int unsigned PAYLOAD_BYTES = crcpf_pkg::PayloadBytesDef,
    localparam int unsigned CntW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    // framed output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic        m_axis_tlast,  // frame_end, on the crc high word
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    crcpf_pkg::t_dp_cmd  cmd;
    crcpf_pkg::t_dp_stat stat;
    logic [CntW-1:0]     addr;
    logic [7:0]          r_header;
    logic                hdr_sel;

    // register map: header_byte at byte address 0, other words read as zero
    assign hdr_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = hdr_sel ? {24'h000000, r_header} : 32'h00000000;

    // header takes effect on the next frame sent; the user writes it only while idle, not enforced by the block
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= crcpf_pkg::HeaderReset;
        end else if (psel && penable && pwrite && pready && hdr_sel) begin
            r_header <= pwdata[7:0];
        end
    end

    // sequencer: collect, then header, payload words, crc low, crc high
    crcpf_ctrl #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_addr     (addr)
    );

    // payload store, running crc and output register
    crcpf_dp #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_addr      (addr),
        .i_data      (s_axis_tdata),
        .i_header    (r_header),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_byte  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule
